[rtl/bitmap_block_allocator_core_assert.svh]
// Assertion macros for the block allocator core.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef BITMAP_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`define BITMAP_BLOCK_ALLOCATOR_CORE_ASSERT_SVH

// Check that a property holds at every clock edge outside reset.
`define BBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define BBA_ASSERT_NEVER(lbl, cond, msg) \
  `BBA_ASSERT(lbl, !(cond), msg)

`endif

[rtl/bba_pkg.sv]
// Shared constants for the bitmap block allocator: field widths, operation kinds
// and status codes. No dependencies.
`timescale 1ns / 1ps

package bba_pkg;

  localparam int unsigned BLOCK_W   = 12;  // block number field
  localparam int unsigned TOTAL_W   = 13;  // total_blocks register
  localparam int unsigned IDX_W     = 13;  // internal block index, holds any limit
  localparam int unsigned WORD_W    = 32;  // bitmap bits read per cycle
  localparam int unsigned BIT_SEL_W = 5;   // bit position within a word
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned TDATA_W   = 16;  // block number padded to bytes

  localparam logic [TOTAL_W-1:0] TOTAL_RESET = 13'd4096;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OUT_OF_BLKS  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_OUT_OF_RANGE = 2'd3;

endpackage

[rtl/bitmap_block_allocator_core.sv]
// First-fit bitmap block allocator: top level, bitmap memory and scan sequencer.
// Depends on bba_pkg and bitmap_block_allocator_core_assert.svh.
`timescale 1ns / 1ps

// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata[11:0] block_number, tuser kind
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata[11:0] result_block, tuser status
// cfg       in   cfg_valid_i/cfg_ready_o      cfg_data_i total_blocks
//
// Allocate: one 32-bit bitmap word is read and checked per cycle, from word 0 up to
//   the first word with a free bit or the block limit; one memory read port sets
//   this rate.
// Free: read the word, then check and write back. Out-of-range frees and
//   allocates with a zero limit load their result straight from idle.
// Reset: per-word valid flags clear the whole bitmap at once; no clearing pass.
// Stalls: the result sits in an output register; a new transaction is taken only
//   in idle when that register is empty or being drained.

module bitmap_block_allocator_core #(
  parameter int unsigned NUM_BLOCKS = 4096
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // request channel
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [bba_pkg::TDATA_W-1:0]           s_axis_tdata,  // [11:0] block_number
  input  logic                                  s_axis_tuser,  // [0] kind
  // response channel
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [bba_pkg::TDATA_W-1:0]           m_axis_tdata,  // [11:0] result_block
  output logic [bba_pkg::STATUS_W-1:0]          m_axis_tuser,  // [1:0] status
  // configuration write channel
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [bba_pkg::TOTAL_W-1:0]           cfg_data_i     // total_blocks
);

  `include "bitmap_block_allocator_core_assert.svh"

  localparam int unsigned IDX_W   = bba_pkg::IDX_W;
  localparam int unsigned WORD_W  = bba_pkg::WORD_W;
  localparam int unsigned SEL_W   = bba_pkg::BIT_SEL_W;
  // Blocks above the largest possible limit are never touched, so no storage.
  localparam int unsigned MAX_LIMIT  = (1 << bba_pkg::TOTAL_W) - 1;
  localparam int unsigned MAP_BLOCKS = (NUM_BLOCKS < MAX_LIMIT) ? NUM_BLOCKS : MAX_LIMIT;
  localparam int unsigned WORDS      = (MAP_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int unsigned WORD_AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

  // Sequencer state codes.
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ALLOC = 2'd1;
  localparam logic [1:0] ST_FREE  = 2'd2;

  logic [1:0]                      state_q, state_d;
  logic [IDX_W-1:0]                base_q, base_d;     // first block of the word read back
  logic [bba_pkg::BLOCK_W-1:0]     blk_q, blk_d;       // block being freed
  logic [bba_pkg::TOTAL_W-1:0]     total_q;

  // Bitmap storage: one word per 32 blocks, plus a valid flag per word so that
  // reset frees everything at once. An invalid word reads as all free.
  logic [WORD_W-1:0]               map_mem [WORDS];
  logic [WORDS-1:0]                word_vld_q;
  logic [WORD_W-1:0]               rd_data_q;
  logic                            rd_vld_q;
  logic [WORD_AW-1:0]              rd_addr;
  logic [WORD_W-1:0]               rd_word;
  logic                            wr_en;
  logic [WORD_AW-1:0]              wr_addr;
  logic [WORD_W-1:0]               wr_data;

  // Output register.
  logic                            out_valid_q, out_valid_d;
  logic [bba_pkg::BLOCK_W-1:0]     out_block_q;
  logic [bba_pkg::STATUS_W-1:0]    out_status_q;
  logic                            load;
  logic [bba_pkg::BLOCK_W-1:0]     load_block;
  logic [bba_pkg::STATUS_W-1:0]    load_status;

  // Scan datapath.
  logic [IDX_W-1:0]                limit;
  logic [IDX_W-1:0]                remain;
  logic [IDX_W:0]                  next_base;
  logic [WORD_W-1:0]               beyond;
  logic [WORD_W-1:0]               free_bits;
  logic [WORD_W-1:0]               first_free;
  logic [SEL_W-1:0]                free_sel;
  logic                            found;
  logic [IDX_W-1:0]                alloc_idx;
  logic [IDX_W-1:0]                in_idx;
  logic                            in_acc;
  logic                            free_hit;

  // The usable limit is total_blocks saturated at the bitmap size.
  assign limit = (32'(total_q) > NUM_BLOCKS) ? IDX_W'(NUM_BLOCKS) : IDX_W'(total_q);

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= bba_pkg::TOTAL_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      total_q <= cfg_data_i;
    end
  end

  // Take a transaction only from idle, with the output slot free or draining.
  assign s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_idx        = IDX_W'(s_axis_tdata[bba_pkg::BLOCK_W-1:0]);

  assign rd_word = rd_vld_q ? rd_data_q : '0;

  // Mark bits at or past the limit as used so the scan never hands them out.
  assign remain    = limit - base_q;
  assign next_base = {1'b0, base_q} + (IDX_W + 1)'(WORD_W);

  always_comb begin
    for (int j = 0; j < WORD_W; j++) begin
      beyond[j] = (IDX_W'(j) >= remain);
    end
  end

  // Isolate the lowest free bit with one add, then encode it.
  assign free_bits  = ~(rd_word | beyond);
  assign first_free = free_bits & (~free_bits + WORD_W'(1));
  assign found      = |free_bits;

  always_comb begin
    free_sel = '0;
    for (int j = 0; j < WORD_W; j++) begin
      if (first_free[j]) free_sel = free_sel | SEL_W'(j);
    end
  end

  assign alloc_idx = base_q + IDX_W'(free_sel);
  assign free_hit  = rd_word[blk_q[SEL_W-1:0]];

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    base_d      = base_q;
    blk_d       = blk_q;
    rd_addr     = WORD_AW'(IDX_W'(blk_q) >> SEL_W);
    wr_en       = 1'b0;
    wr_addr     = WORD_AW'(base_q >> SEL_W);
    wr_data     = rd_word | first_free;
    load        = 1'b0;
    load_block  = '0;
    load_status = bba_pkg::ST_OK;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tuser == bba_pkg::KIND_ALLOC) begin
          rd_addr = '0;
        end else begin
          rd_addr = WORD_AW'(in_idx >> SEL_W);
        end
        if (in_acc) begin
          if (s_axis_tuser == bba_pkg::KIND_ALLOC) begin
            base_d = '0;
            if (limit == '0) begin
              load        = 1'b1;
              load_status = bba_pkg::ST_OUT_OF_BLKS;
            end else begin
              state_d = ST_ALLOC;
            end
          end else begin
            blk_d = s_axis_tdata[bba_pkg::BLOCK_W-1:0];
            if (in_idx >= limit) begin
              load        = 1'b1;
              load_block  = s_axis_tdata[bba_pkg::BLOCK_W-1:0];
              load_status = bba_pkg::ST_OUT_OF_RANGE;
            end else begin
              state_d = ST_FREE;
            end
          end
        end
      end
      ST_ALLOC: begin
        // Prefetch the next word while checking this one.
        rd_addr = WORD_AW'(next_base >> SEL_W);
        if (found) begin
          wr_en      = 1'b1;
          load       = 1'b1;
          load_block = alloc_idx[bba_pkg::BLOCK_W-1:0];
          state_d    = ST_IDLE;
        end else if (next_base >= {1'b0, limit}) begin
          load        = 1'b1;
          load_status = bba_pkg::ST_OUT_OF_BLKS;
          state_d     = ST_IDLE;
        end else begin
          base_d = next_base[IDX_W-1:0];
        end
      end
      ST_FREE: begin
        wr_addr    = WORD_AW'(IDX_W'(blk_q) >> SEL_W);
        wr_data    = rd_word & ~(WORD_W'(1) << blk_q[SEL_W-1:0]);
        wr_en      = free_hit;
        load       = 1'b1;
        load_block = blk_q;
        load_status = free_hit ? bba_pkg::ST_OK : bba_pkg::ST_ALREADY_FREE;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      word_vld_q  <= '0;
      rd_vld_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      rd_vld_q    <= word_vld_q[rd_addr];
      if (wr_en) word_vld_q[wr_addr] <= 1'b1;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    blk_q  <= blk_d;
    if (load) begin
      out_block_q  <= load_block;
      out_status_q <= load_status;
    end
  end

  // Bitmap memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) map_mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= map_mem[rd_addr];
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = bba_pkg::TDATA_W'(out_block_q);
  assign m_axis_tuser  = out_status_q;

  // Assertions.
  `BBA_ASSERT_NEVER(a_busy_with_result, (state_q != ST_IDLE) && out_valid_q,
    "result pending while an operation is still in progress")
  `BBA_ASSERT(a_scan_below_limit, (state_q == ST_ALLOC) |-> (base_q < limit),
    "allocate scan reached a word past the block limit")
  `BBA_ASSERT(a_alloc_in_range, ((state_q == ST_ALLOC) && found) |-> (alloc_idx < limit),
    "allocated block lies at or beyond the block limit")
  `BBA_ASSERT(a_accept_tracked, in_acc |=> ((state_q != ST_IDLE) || out_valid_q),
    "accepted transaction left neither work in progress nor a result")

endmodule
